// File: design/omrs_pkg.sv
// Shared types and constants for the ordered multiset rank/select block.
// No dependencies.
package omrs_pkg;

	localparam logic [2:0] REQ_INSERT = 3'd0;
	localparam logic [2:0] REQ_DELETE = 3'd1;
	localparam logic [2:0] REQ_RANK   = 3'd2;
	localparam logic [2:0] REQ_SELECT = 3'd3;
	localparam logic [2:0] REQ_PRED   = 3'd4;
	localparam logic [2:0] REQ_SUCC   = 3'd5;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam int KEY_W  = 32;
	localparam int RANK_W = 11;

	typedef enum logic [2:0] {
		OP_INSERT = 3'd0,
		OP_DELETE = 3'd1,
		OP_RANK   = 3'd2,
		OP_SELECT = 3'd3,
		OP_PRED   = 3'd4,
		OP_SUCC   = 3'd5,
		OP_BAD    = 3'd6
	} op_t;

	typedef struct packed {
		op_t                      op;
		logic                     upper;   // search for first key above, not first not below
		logic signed [KEY_W-1:0]  key;
		logic [RANK_W-1:0]        rank_in;
	} cmd_t;

	typedef struct packed {
		logic signed [KEY_W-1:0]  value;
		logic [RANK_W-1:0]        rank;
		logic [1:0]               status;
	} res_t;

endpackage

// File: design/ordered_multiset_rank_select_top.sv
// Top level of the ordered multiset with rank and select queries.
// Depends on omrs_pkg, omrs_front, omrs_back and omrs_queue.
//
// Keeps up to CAPACITY signed 32-bit keys (duplicates kept) in one sorted
// single-port-read, single-port-write memory. Requests enter a two-deep
// command queue through push/full and results leave a two-deep result queue
// through empty/pop, so either side may stall without blocking the other.
// One request is carried out at a time by the back end. Its cost is set by
// the memory's one read per cycle: a binary search takes a read state and a
// compare state per halving of the range over the n stored keys, followed by
// dispatch, answer fetch and result transfer. Insert and delete also shift
// the tail of the store one entry per read and write state pair, so they add
// work for each entry between pos, the key's place, and the end. Key-at-rank
// needs no search. Every request yields exactly one result transfer with a
// status: ok, not found/out of range, or store full. The memory needs no
// clearing after reset; only the entry count and control state are reset.
module ordered_multiset_rank_select_top #(
	parameter int CAPACITY = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [2:0]         req_type,
	input  logic signed [31:0] key,
	input  logic [10:0]        rank_in,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] answer_value,
	output logic [10:0]        answer_rank,
	output logic [1:0]         status
);
	omrs_pkg::cmd_t cmd;
	logic           cmd_empty;
	logic           cmd_pop;
	omrs_pkg::res_t res_in;
	logic           res_push;
	logic           res_full;
	logic [$bits(omrs_pkg::res_t)-1:0] res_bits;
	omrs_pkg::res_t res_out;

	// decode and buffer incoming requests
	omrs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.req_type (req_type),
		.key      (key),
		.rank_in  (rank_in),
		.cmd_pop  (cmd_pop),
		.cmd_empty(cmd_empty),
		.cmd      (cmd)
	);

	// execute one command at a time against the sorted store
	omrs_back #(.CAPACITY(CAPACITY)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_in)
	);

	// hold finished results until the consumer takes them
	omrs_queue #(.W($bits(omrs_pkg::res_t))) u_resq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.din   (res_in),
		.full  (res_full),
		.pop   (pop),
		.dout  (res_bits),
		.empty (empty)
	);

	assign res_out      = omrs_pkg::res_t'(res_bits);
	assign answer_value = res_out.value;
	assign answer_rank  = res_out.rank;
	assign status       = res_out.status;

endmodule

// File: design/omrs_queue.sv
// Two-entry queue of opaque words, used between the front, the back and the result port.
// No dependencies.
module omrs_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);
	logic [W-1:0] slot_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;
	logic         do_push;
	logic         do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign dout    = slot_q[rp_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= !wp_q;
			end
			if (do_pop) begin
				rp_q <= !rp_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// File: design/omrs_front.sv
// Front end: decodes requests into commands and queues them for the back end.
// Depends on omrs_pkg and omrs_queue.
module omrs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [2:0]          req_type,
	input  logic signed [31:0]  key,
	input  logic [10:0]         rank_in,
	input  logic                cmd_pop,
	output logic                cmd_empty,
	output omrs_pkg::cmd_t      cmd
);
	omrs_pkg::cmd_t dec;
	logic [$bits(omrs_pkg::cmd_t)-1:0] cmd_bits;

	always_comb begin
		dec.key     = key;
		dec.rank_in = rank_in;
		dec.upper   = 1'b0;
		unique case (req_type)
			omrs_pkg::REQ_INSERT: begin
				dec.op    = omrs_pkg::OP_INSERT;
				dec.upper = 1'b1;
			end
			omrs_pkg::REQ_DELETE: dec.op = omrs_pkg::OP_DELETE;
			omrs_pkg::REQ_RANK:   dec.op = omrs_pkg::OP_RANK;
			omrs_pkg::REQ_SELECT: dec.op = omrs_pkg::OP_SELECT;
			omrs_pkg::REQ_PRED:   dec.op = omrs_pkg::OP_PRED;
			omrs_pkg::REQ_SUCC: begin
				dec.op    = omrs_pkg::OP_SUCC;
				dec.upper = 1'b1;
			end
			default:              dec.op = omrs_pkg::OP_BAD;
		endcase
	end

	omrs_queue #(.W($bits(omrs_pkg::cmd_t))) u_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (dec),
		.full  (full),
		.pop   (cmd_pop),
		.dout  (cmd_bits),
		.empty (cmd_empty)
	);

	assign cmd = omrs_pkg::cmd_t'(cmd_bits);

endmodule

// File: design/omrs_back.sv
// Back end: sorted key memory, binary search, shift on insert/delete, answer fetch.
// Depends on omrs_pkg.
module omrs_back #(
	parameter int CAPACITY = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  omrs_pkg::cmd_t  cmd,
	input  logic            cmd_empty,
	output logic            cmd_pop,
	input  logic            res_full,
	output logic            res_push,
	output omrs_pkg::res_t  res
);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int AW   = $clog2(CAPACITY);
	localparam int CMPW = (CW > 11) ? CW : 11;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_SRCH = 10'b0000000010,
		S_SCMP = 10'b0000000100,
		S_POST = 10'b0000001000,
		S_FRD  = 10'b0000010000,
		S_FUSE = 10'b0000100000,
		S_IRD  = 10'b0001000000,
		S_IWR  = 10'b0010000000,
		S_DRD  = 10'b0100000000,
		S_DWR  = 10'b1000000000
	} state_t;

	state_t          state_q;
	omrs_pkg::cmd_t  cmd_q;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   lo_q;
	logic [CW-1:0]   hi_q;
	logic [CW-1:0]   idx_q;
	logic [AW-1:0]   faddr_q;
	logic            done_q;
	omrs_pkg::res_t  res_q;

	logic [31:0]     mem [CAPACITY];
	logic [31:0]     rd_q;
	logic [AW-1:0]   raddr;
	logic            we;
	logic [AW-1:0]   waddr;
	logic [31:0]     wdata;
	logic [CW-1:0]   mid;
	logic            go_right;
	logic [CMPW-1:0] rank_ext;
	logic [CMPW-1:0] cnt_ext;
	logic            start;

	assign mid      = lo_q + ((hi_q - lo_q) >> 1);
	assign go_right = cmd_q.upper ? ($signed(rd_q) <= cmd_q.key) : ($signed(rd_q) < cmd_q.key);
	assign rank_ext = CMPW'(cmd.rank_in);
	assign cnt_ext  = CMPW'(cnt_q);
	assign start    = (state_q == S_IDLE) && !done_q && !cmd_empty && !res_full;
	assign cmd_pop  = start;
	assign res_push = done_q;
	assign res      = res_q;

	// read address for the next registered memory read
	always_comb begin
		raddr = faddr_q;
		unique case (state_q)
			S_SRCH:  raddr = mid[AW-1:0];
			S_IRD:   raddr = AW'(idx_q - CW'(1));
			S_DRD:   raddr = AW'(idx_q + CW'(1));
			default: raddr = faddr_q;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = rd_q;
		if (state_q == S_IRD && idx_q == lo_q && !done_q) begin
			we    = 1'b1;
			wdata = cmd_q.key;
		end else if (state_q == S_IWR || state_q == S_DWR) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cmd_q        <= cmd;
			lo_q         <= '0;
			hi_q         <= cnt_q;
			res_q.value  <= '0;
			res_q.rank   <= '0;
			res_q.status <= omrs_pkg::ST_OK;
			if (cmd.op == omrs_pkg::OP_BAD) begin
				res_q.status <= omrs_pkg::ST_MISS;
			end else if (cmd.op == omrs_pkg::OP_INSERT && cnt_q == CW'(CAPACITY)) begin
				res_q.status <= omrs_pkg::ST_FULL;
			end else if (cmd.op == omrs_pkg::OP_SELECT) begin
				if (rank_ext != '0 && rank_ext <= cnt_ext) begin
					faddr_q <= AW'(cmd.rank_in - 11'd1);
				end else begin
					res_q.value  <= -32'sd1;
					res_q.status <= omrs_pkg::ST_MISS;
				end
			end
		end
		unique case (state_q)
			S_SCMP: begin
				if (go_right) begin
					lo_q <= mid + CW'(1);
				end else begin
					hi_q <= mid;
				end
			end
			S_POST: begin
				idx_q <= cnt_q;
				unique case (cmd_q.op)
					omrs_pkg::OP_RANK: res_q.rank <= 11'(lo_q + CW'(1));
					omrs_pkg::OP_PRED: begin
						if (lo_q != '0) begin
							faddr_q <= AW'(lo_q - CW'(1));
						end else begin
							res_q.status <= omrs_pkg::ST_MISS;
						end
					end
					omrs_pkg::OP_DELETE, omrs_pkg::OP_SUCC: begin
						if (lo_q < cnt_q) begin
							faddr_q <= lo_q[AW-1:0];
						end else begin
							res_q.status <= omrs_pkg::ST_MISS;
						end
					end
					default: ;
				endcase
			end
			S_FUSE: begin
				if (cmd_q.op == omrs_pkg::OP_DELETE) begin
					idx_q <= lo_q;
					if ($signed(rd_q) != cmd_q.key) begin
						res_q.status <= omrs_pkg::ST_MISS;
					end
				end else begin
					res_q.value <= rd_q;
				end
			end
			S_IWR:   idx_q <= idx_q - CW'(1);
			S_DWR:   idx_q <= idx_q + CW'(1);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (cmd.op == omrs_pkg::OP_BAD ||
							(cmd.op == omrs_pkg::OP_INSERT && cnt_q == CW'(CAPACITY))) begin
							done_q <= 1'b1;
						end else if (cmd.op == omrs_pkg::OP_SELECT) begin
							if (rank_ext != '0 && rank_ext <= cnt_ext) begin
								state_q <= S_FRD;
							end else begin
								done_q <= 1'b1;
							end
						end else begin
							state_q <= S_SRCH;
						end
					end
				end
				S_SRCH:  state_q <= (lo_q == hi_q) ? S_POST : S_SCMP;
				S_SCMP:  state_q <= S_SRCH;
				S_POST: begin
					unique case (cmd_q.op)
						omrs_pkg::OP_INSERT: state_q <= S_IRD;
						omrs_pkg::OP_PRED: begin
							if (lo_q != '0) begin
								state_q <= S_FRD;
							end else begin
								state_q <= S_IDLE;
								done_q  <= 1'b1;
							end
						end
						omrs_pkg::OP_DELETE, omrs_pkg::OP_SUCC: begin
							if (lo_q < cnt_q) begin
								state_q <= S_FRD;
							end else begin
								state_q <= S_IDLE;
								done_q  <= 1'b1;
							end
						end
						default: begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end
					endcase
				end
				S_FRD:   state_q <= S_FUSE;
				S_FUSE: begin
					if (cmd_q.op == omrs_pkg::OP_DELETE && $signed(rd_q) == cmd_q.key) begin
						state_q <= S_DRD;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				S_IRD: begin
					if (idx_q == lo_q) begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= S_IWR;
					end
				end
				S_IWR:   state_q <= S_IRD;
				S_DRD: begin
					if (idx_q + CW'(1) >= cnt_q) begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= S_DWR;
					end
				end
				S_DWR:   state_q <= S_DRD;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: design/omrs_checker.sv
// Port-level checks for the ordered multiset rank/select top level, and its bind.
// Depends on ordered_multiset_rank_select_top and omrs_pkg.
module omrs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               push,
	input logic               full,
	input logic               empty,
	input logic               pop,
	input logic signed [31:0] answer_value,
	input logic [10:0]        answer_rank,
	input logic [1:0]         status
);
	// request queue fills only through a push
	a_full_needs_push: assert property (@(posedge clk) disable iff (!arst_n)
		!full && !push |=> !full) else $error("full rose without a push");

	// a waiting result holds until popped
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(answer_value) && $stable(status))
		else $error("waiting result changed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> status != 2'd3) else $error("undefined status code");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && status == omrs_pkg::ST_FULL |-> answer_value == 0 && answer_rank == 0)
		else $error("refused insert carries an answer");

	a_rank_only: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && answer_rank != 0 |-> answer_value == 0 && status == omrs_pkg::ST_OK)
		else $error("rank result mixed with a value");

endmodule

bind ordered_multiset_rank_select_top omrs_checker u_omrs_checker (.*);
